[sv/piw_pkg.sv]
// Shared types and constants for the point-in-polygon winding unit.
`timescale 1ns / 1ps
package piw_pkg;

  // Fixed field widths of the interface
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned LOC_W      = 2;
  localparam int unsigned CFG_CNT_W  = 5;
  localparam int unsigned EPS_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned OUT_DATA_W = ((LOC_W + 7) / 8) * 8;
  localparam int unsigned MIN_CORNERS = 3;

  // Item kinds carried on in_tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 1'b1;

  // Result codes
  localparam logic [LOC_W-1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [LOC_W-1:0] LOC_INSIDE   = 2'd1;
  localparam logic [LOC_W-1:0] LOC_BOUNDARY = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_CNT_W-1:0] CORNER_COUNT_RST = 5'd3;
  localparam logic [EPS_W-1:0]     EPSILON_RST      = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

[sv/point_in_polygon_winding_unit.sv]
// Top level: corner store and winding-number walk over the polygon edges.
`timescale 1ns / 1ps
// Point-in-polygon test by winding number, exact fixed-point arithmetic.
// Input channel (in_*): in_tuser selects the item kind. A load item writes
// one corner (x, y) into the corner store at corner_index and yields no
// result. A query item walks every edge of the first corner_count
// corners and yields one location item on the out_* channel
// (outside, inside or on the boundary).
// A query reads the corners through the single read port of the corner
// store, one corner per cycle, corner_count + 1 reads in all, followed by a
// product stage, a difference stage and the winding update. A new item is
// taken once the result has moved into the output register, so a query
// must finish before the next item is taken; loads are taken one per cycle
// while idle.
// If the receiver stalls, the result waits in the output register while
// loads and a further query are still taken; that query holds only at its
// end until the output register frees.
// Configuration (cfg_*) is always ready; write it only while idle.
// Reset (rst_n low, synchronous) empties the pipeline and output and sets
// corner_count to 3 and collinear_epsilon to 1. Corners are undefined
// until loaded.
module point_in_polygon_winding_unit #(
  parameter int unsigned MAX_CORNERS = 16,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, low bit up: corner_index, coord_x, coord_y, zero pad
  input  logic [((piw_pkg::IDX_W + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: operation
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata, low bit up: location, zero pad
  output logic [piw_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [piw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [piw_pkg::EPS_W-1:0]           cfg_data
);

  localparam int unsigned AW    = $clog2(MAX_CORNERS);
  localparam int unsigned CNT_N = $clog2(MAX_CORNERS + 1);
  localparam int unsigned CNT_W = (CNT_N > piw_pkg::CFG_CNT_W) ? CNT_N : piw_pkg::CFG_CNT_W;
  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned XW    = PW + 1;
  localparam int unsigned CMPW  = ((XW > piw_pkg::EPS_W) ? XW : piw_pkg::EPS_W) + 1;
  localparam int unsigned WNW   = CNT_N + 2;
  localparam int unsigned MW    = 2 * COORD_WIDTH;

  // ---------------------------------------------------------------- config
  logic [piw_pkg::CFG_CNT_W-1:0] cc_r;
  logic [piw_pkg::EPS_W-1:0]     eps_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r  <= piw_pkg::CORNER_COUNT_RST;
      eps_r <= piw_pkg::EPSILON_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        piw_pkg::REG_CORNER_COUNT: cc_r  <= cfg_data[piw_pkg::CFG_CNT_W-1:0];
        piw_pkg::REG_EPSILON:      eps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  logic [piw_pkg::IDX_W-1:0]    in_idx;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic                         in_acc;

  assign in_idx = in_tdata[piw_pkg::IDX_W-1:0];
  assign in_x   = in_tdata[piw_pkg::IDX_W +: COORD_WIDTH];
  assign in_y   = in_tdata[piw_pkg::IDX_W + COORD_WIDTH +: COORD_WIDTH];
  assign in_acc = in_tvalid && in_tready;

  // clamp the corner count to the legal range
  logic [CNT_W-1:0] cc_ext;
  logic [CNT_W-1:0] n_nxt;

  always_comb begin
    cc_ext = CNT_W'(cc_r);
    priority if (cc_ext < CNT_W'(piw_pkg::MIN_CORNERS)) begin
      n_nxt = CNT_W'(piw_pkg::MIN_CORNERS);
    end else if (cc_ext > CNT_W'(MAX_CORNERS)) begin
      n_nxt = CNT_W'(MAX_CORNERS);
    end else begin
      n_nxt = cc_ext;
    end
  end

  // ---------------------------------------------------------------- control
  piw_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] step_r;
  logic             issuing_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic             d_vld_r, d_last_r;
  logic             out_free;
  logic [piw_pkg::LOC_W-1:0] loc_r, loc_nxt;

  assign in_tready = (state_r == piw_pkg::ST_IDLE);
  assign out_free  = !out_tvalid || out_tready;
  assign wr_en     = in_acc && (in_tuser == piw_pkg::OP_LOAD)
                     && (32'(in_idx) < 32'(MAX_CORNERS));
  assign wr_addr   = AW'(in_idx);
  assign rd_en     = (state_r == piw_pkg::ST_RUN) && issuing_r;
  // first read is the last corner in use, then corners 0 upward
  assign rd_addr   = (step_r == '0) ? AW'(n_r - CNT_W'(1)) : AW'(step_r - CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      piw_pkg::ST_IDLE: begin
        if (in_acc && (in_tuser == piw_pkg::OP_QUERY)) state_nxt = piw_pkg::ST_RUN;
      end
      piw_pkg::ST_RUN: begin
        if (d_vld_r && d_last_r) state_nxt = piw_pkg::ST_FINISH;
      end
      piw_pkg::ST_FINISH: begin
        if (out_free) state_nxt = piw_pkg::ST_IDLE;
      end
      default: state_nxt = piw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= piw_pkg::ST_IDLE;
      issuing_r <= 1'b0;
      step_r    <= '0;
      n_r       <= CNT_W'(piw_pkg::MIN_CORNERS);
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_tuser == piw_pkg::OP_QUERY)) begin
        issuing_r <= 1'b1;
        step_r    <= '0;
        n_r       <= n_nxt;
      end else if (rd_en) begin
        if (step_r == n_r) begin
          issuing_r <= 1'b0;
        end else begin
          step_r <= step_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= in_x;
      py_r <= in_y;
    end
  end

  // ---------------------------------------------------------------- corner store
  logic [MW-1:0] mem [MAX_CORNERS];
  logic [MW-1:0] rd_data_r;
  logic          rd_vld_r, rd_first_r, rd_last_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {in_y, in_x};
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_first_r <= (step_r == '0);
      rd_last_r  <= (step_r == n_r);
    end
  end

  // ---------------------------------------------------------------- stage B: products
  logic [MW-1:0] prev_r;
  logic signed [COORD_WIDTH-1:0] sx, sy, ex, ey;
  logic signed [DW-1:0] da, db, dc, dd;
  logic sy_le, ey_gt, in_box;

  assign sx = prev_r[COORD_WIDTH-1:0];
  assign sy = prev_r[MW-1:COORD_WIDTH];
  assign ex = rd_data_r[COORD_WIDTH-1:0];
  assign ey = rd_data_r[MW-1:COORD_WIDTH];

  assign da = DW'(ex) - DW'(sx);
  assign db = DW'(py_r) - DW'(sy);
  assign dc = DW'(px_r) - DW'(sx);
  assign dd = DW'(ey) - DW'(sy);

  assign sy_le  = (sy <= py_r);
  assign ey_gt  = (ey > py_r);
  assign in_box = ((sx <= px_r) || (ex <= px_r)) && ((px_r <= sx) || (px_r <= ex))
                && ((sy <= py_r) || (ey <= py_r)) && ((py_r <= sy) || (py_r <= ey));

  logic signed [PW-1:0] p_r, q_r;
  logic c_vld_r, c_last_r, c_up_r, c_down_r, c_box_r;

  always_ff @(posedge clk) begin
    if (rd_vld_r) prev_r <= rd_data_r;
    p_r      <= PW'(da) * PW'(db);
    q_r      <= PW'(dc) * PW'(dd);
    c_last_r <= rd_last_r;
    c_up_r   <= sy_le && ey_gt;
    c_down_r <= !sy_le && !ey_gt;
    c_box_r  <= in_box;
  end

  // ---------------------------------------------------------------- stage C: cross product
  logic signed [XW-1:0] cross_r;
  logic d_up_r, d_down_r, d_box_r;

  always_ff @(posedge clk) begin
    cross_r  <= XW'(p_r) - XW'(q_r);
    d_last_r <= c_last_r;
    d_up_r   <= c_up_r;
    d_down_r <= c_down_r;
    d_box_r  <= c_box_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      c_vld_r <= rd_vld_r && !rd_first_r;
      d_vld_r <= c_vld_r;
    end
  end

  // ---------------------------------------------------------------- stage D: classify, wind
  logic signed [CMPW-1:0] cross_e, eps_e;
  logic collinear, left_side, right_side;
  logic signed [WNW-1:0] wn_r, wn_nxt;
  logic bnd_r, bnd_nxt;

  assign cross_e    = CMPW'(cross_r);
  assign eps_e      = CMPW'(eps_r);
  assign collinear  = cross_r[XW-1] ? (cross_e > -eps_e) : (cross_e < eps_e);
  assign left_side  = !collinear && !cross_r[XW-1] && (cross_r != '0);
  assign right_side = !collinear && !left_side;

  always_comb begin
    wn_nxt  = wn_r;
    bnd_nxt = bnd_r;
    if (d_vld_r) begin
      if (collinear && d_box_r) bnd_nxt = 1'b1;
      if (d_up_r && left_side) begin
        wn_nxt = wn_r + WNW'(1);
      end else if (d_down_r && right_side) begin
        wn_nxt = wn_r - WNW'(1);
      end
    end
    priority if (bnd_nxt) begin
      loc_nxt = piw_pkg::LOC_BOUNDARY;
    end else if (wn_nxt != '0) begin
      loc_nxt = piw_pkg::LOC_INSIDE;
    end else begin
      loc_nxt = piw_pkg::LOC_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wn_r  <= '0;
      bnd_r <= 1'b0;
    end else if (in_acc) begin
      wn_r  <= '0;
      bnd_r <= 1'b0;
    end else begin
      wn_r  <= wn_nxt;
      bnd_r <= bnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (d_vld_r && d_last_r) loc_r <= loc_nxt;
  end

  // ---------------------------------------------------------------- output register
  logic                      out_vld_r;
  logic [piw_pkg::LOC_W-1:0] out_loc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((state_r == piw_pkg::ST_FINISH) && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == piw_pkg::ST_FINISH) && out_free) out_loc_r <= loc_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = piw_pkg::OUT_DATA_W'(out_loc_r);

  // ---------------------------------------------------------------- checks
  a_edge_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> (state_r == piw_pkg::ST_RUN))
    else $error("edge result outside a query walk");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == piw_pkg::ST_RUN) |-> (step_r <= n_r))
    else $error("read step past the last corner");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r)) |-> $past(state_r == piw_pkg::ST_FINISH))
    else $error("result appeared without a finished query");

  a_loc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_loc_r == piw_pkg::LOC_OUTSIDE || out_loc_r == piw_pkg::LOC_INSIDE
                   || out_loc_r == piw_pkg::LOC_BOUNDARY))
    else $error("invalid location code");

endmodule

[test/point_in_polygon_winding_unit_tb.sv]
// Testbench for the point-in-polygon winding unit: directed and random polygon queries.
`timescale 1ns / 1ps
module point_in_polygon_winding_unit_tb;

  localparam int unsigned NCORNERS = 16;
  localparam int unsigned CW = 16;
  localparam int unsigned IN_DATA_W = ((piw_pkg::IDX_W + 2 * CW + 7) / 8) * 8;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET = 1050;
  localparam int QUIET_TAIL = 150;
  localparam int MAX_REPORTS = 10;
  localparam longint CMAX = 32767;
  localparam longint CMIN = -32768;
  localparam real PI = 3.14159265358979;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [piw_pkg::IDX_W-1:0] idx_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
  } corner_t;

  logic clk = 1'b0;
  logic rst_n;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic in_tvalid;
  logic in_tready;
  logic [piw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready;
  logic cfg_valid;
  logic cfg_ready;
  logic [piw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [piw_pkg::EPS_W-1:0] cfg_data;

  // Predictor state: corner store and configuration as the block should hold them
  corner_t poly_store [NCORNERS];
  logic [piw_pkg::CFG_CNT_W-1:0] corner_count_q;
  logic [piw_pkg::EPS_W-1:0] epsilon_q;
  logic [piw_pkg::LOC_W-1:0] loc_expected [$];

  int err_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b0;

  point_in_polygon_winding_unit #(
    .MAX_CORNERS(NCORNERS),
    .COORD_WIDTH(CW)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic coord_t to_coord(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic int used_corners();
    int n;
    n = corner_count_q;
    if (n < piw_pkg::MIN_CORNERS) n = piw_pkg::MIN_CORNERS;
    if (n > NCORNERS) n = NCORNERS;
    return n;
  endfunction

  // Sign of a*b - c*d, zero inside the collinear band
  function automatic int side_of_edge(longint a, longint b, longint c, longint d);
    longint xprod;
    longint mag;
    xprod = a * b - c * d;
    mag = (xprod < 0) ? -xprod : xprod;
    if (mag < longint'({32'd0, epsilon_q})) return 0;
    return (xprod > 0) ? 1 : -1;
  endfunction

  function automatic logic [piw_pkg::LOC_W-1:0] predict_location(longint px, longint py);
    int n;
    int i;
    int j;
    int side;
    int winding;
    longint sx;
    longint sy;
    longint ex;
    longint ey;
    n = used_corners();
    winding = 0;
    j = n - 1;
    for (i = 0; i < n; i++) begin
      sx = poly_store[j].x;
      sy = poly_store[j].y;
      ex = poly_store[i].x;
      ey = poly_store[i].y;
      side = side_of_edge(ex - sx, py - sy, px - sx, ey - sy);
      if (side == 0 && ((sx < ex) ? sx : ex) <= px && px <= ((sx < ex) ? ex : sx) &&
          ((sy < ey) ? sy : ey) <= py && py <= ((sy < ey) ? ey : sy))
        return piw_pkg::LOC_BOUNDARY;
      if (sy <= py) begin
        if (ey > py && side > 0) winding++;
      end else if (ey <= py && side < 0) begin
        winding--;
      end
      j = i;
    end
    return (winding != 0) ? piw_pkg::LOC_INSIDE : piw_pkg::LOC_OUTSIDE;
  endfunction

  function automatic void note_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // Enter and leave at a falling edge; valid stays high for a following item
  task automatic send_item(logic op, idx_t idx, coord_t cx, coord_t cy);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(IN_DATA_W - piw_pkg::IDX_W - 2 * CW){1'b0}}, cy, cx, idx};
    do @(posedge clk); while (!in_tready);
    if (op == piw_pkg::OP_LOAD) poly_store[idx] = '{x: cx, y: cy};
    else loc_expected.push_back(predict_location(cx, cy));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_corner(idx_t idx, coord_t cx, coord_t cy);
    send_item(piw_pkg::OP_LOAD, idx, cx, cy);
  endtask

  task automatic query_point(coord_t cx, coord_t cy);
    idx_t junk;
    junk = idx_t'($urandom);
    send_item(piw_pkg::OP_QUERY, junk, cx, cy);
  endtask

  task automatic write_reg(logic [piw_pkg::CFG_IDX_W-1:0] idx,
                           logic [piw_pkg::EPS_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == piw_pkg::REG_CORNER_COUNT) corner_count_q = value[piw_pkg::CFG_CNT_W-1:0];
    else epsilon_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every location has come back, then let the bench idle for a settle period
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (loc_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_default_triangle();
    load_corner(idx_t'(0), coord_t'(CMIN), coord_t'(CMIN));
    load_corner(idx_t'(1), coord_t'(CMAX), coord_t'(CMIN));
    load_corner(idx_t'(2), '0, coord_t'(CMAX));
    query_point('0, '0);
    query_point(coord_t'(CMIN), coord_t'(CMAX));
    query_point(coord_t'(CMAX), coord_t'(CMIN));
    query_point('0, coord_t'(CMIN));
    query_point(coord_t'(CMAX), coord_t'(CMAX));
    query_point(coord_t'(-1), coord_t'(CMAX));
  endtask

  task automatic test_epsilon_extremes();
    wait_idle();
    // no collinear band: points on edges no longer report boundary
    write_reg(piw_pkg::REG_EPSILON, '0);
    query_point('0, coord_t'(CMIN));
    query_point(coord_t'(CMAX), coord_t'(CMIN));
    wait_idle();
    write_reg(piw_pkg::REG_EPSILON, '1);
    query_point('0, '0);
    query_point(coord_t'(CMIN), coord_t'(CMAX));
  endtask

  task automatic test_count_clamping();
    wait_idle();
    write_reg(piw_pkg::REG_EPSILON, piw_pkg::EPSILON_RST);
    load_corner(idx_t'(3), coord_t'(CMIN), coord_t'(CMAX));
    wait_idle();
    write_reg(piw_pkg::REG_CORNER_COUNT, 32'd0);
    query_point(coord_t'(-20000), coord_t'(20000));
    wait_idle();
    write_reg(piw_pkg::REG_CORNER_COUNT, 32'd2);
    query_point(coord_t'(-20000), coord_t'(20000));
    wait_idle();
    // only the low five bits count: this selects four corners
    write_reg(piw_pkg::REG_CORNER_COUNT, 32'hFFFF_FFE4);
    query_point(coord_t'(-20000), coord_t'(20000));
    query_point(coord_t'(CMIN), '0);
  endtask

  task automatic load_polygon(int n, bit load_all);
    int shape;
    int k;
    int slot;
    longint scale;
    longint cx;
    longint cy;
    longint px;
    longint py;
    real ang;
    real rad;
    bit reverse;
    shape = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: scale = $urandom_range(2, 8);
      1: scale = $urandom_range(9, 300);
      2: scale = $urandom_range(301, 6000);
      default: scale = $urandom_range(6001, 32767);
    endcase
    cx = longint'($urandom_range(0, 2 * (CMAX - scale))) - (CMAX - scale);
    cy = longint'($urandom_range(0, 2 * (CMAX - scale))) - (CMAX - scale);
    reverse = 1'($urandom_range(0, 1));
    for (k = 0; k < NCORNERS; k++) begin
      if (k >= n && !load_all) break;
      slot = (reverse && k < n) ? n - 1 - k : k;
      case (shape)
        0, 1: begin
          ang = 2.0 * PI * real'(k) / real'(n);
          rad = real'(scale);
          if (shape == 0) begin
            ang = ang + ($urandom_range(0, 600) / 1000.0 - 0.3) * 2.0 * PI / real'(n);
            rad = rad * (0.3 + 0.7 * $urandom_range(0, 1000) / 1000.0);
          end
          px = cx + $rtoi(rad * $cos(ang));
          py = cy + $rtoi(rad * $sin(ang));
        end
        2: begin
          px = cx + longint'($urandom_range(0, 2 * scale)) - scale;
          py = cy + longint'($urandom_range(0, 2 * scale)) - scale;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: px = CMIN;
            1: px = CMAX;
            2: px = 0;
            default: px = coord_t'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: py = CMIN;
            1: py = CMAX;
            2: py = 0;
            default: py = coord_t'($urandom);
          endcase
        end
      endcase
      load_corner(idx_t'(slot), to_coord(px), to_coord(py));
    end
  endtask

  task automatic query_near_polygon(int n);
    int k;
    int i;
    int m;
    longint xlo;
    longint xhi;
    longint ylo;
    longint yhi;
    longint spanx;
    longint spany;
    longint px;
    longint py;
    xlo = CMAX;
    xhi = CMIN;
    ylo = CMAX;
    yhi = CMIN;
    for (i = 0; i < n; i++) begin
      if (poly_store[i].x < xlo) xlo = poly_store[i].x;
      if (poly_store[i].x > xhi) xhi = poly_store[i].x;
      if (poly_store[i].y < ylo) ylo = poly_store[i].y;
      if (poly_store[i].y > yhi) yhi = poly_store[i].y;
    end
    spanx = xhi - xlo;
    spany = yhi - ylo;
    k = $urandom_range(0, n - 1);
    m = (k + 1) % n;
    case ($urandom_range(0, 9))
      0: begin
        px = poly_store[k].x;
        py = poly_store[k].y;
      end
      1: begin
        px = (longint'(poly_store[k].x) + poly_store[m].x) / 2;
        py = (longint'(poly_store[k].y) + poly_store[m].y) / 2;
      end
      2: begin
        // on a corner's level, where crossings are decided
        px = xlo + longint'($urandom_range(0, spanx));
        py = poly_store[k].y;
      end
      3: begin
        px = poly_store[k].x + longint'($urandom_range(0, 2)) - 1;
        py = poly_store[k].y + longint'($urandom_range(0, 2)) - 1;
      end
      4: begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end
      default: begin
        px = xlo - spanx / 4 + longint'($urandom_range(0, spanx + spanx / 2));
        py = ylo - spany / 4 + longint'($urandom_range(0, spany + spany / 2));
      end
    endcase
    query_point(to_coord(px), to_coord(py));
  endtask

  task automatic run_polygon_phase(bit load_all);
    logic [piw_pkg::EPS_W-1:0] count_word;
    logic [piw_pkg::EPS_W-1:0] eps_word;
    int n;
    wait_idle();
    case ($urandom_range(0, 9))
      0: count_word = piw_pkg::MIN_CORNERS;
      1: count_word = NCORNERS;
      2: count_word = $urandom_range(0, 2);
      3: count_word = ($urandom & 32'hFFFF_FFE0) | $urandom_range(17, 31);
      default: count_word = $urandom_range(piw_pkg::MIN_CORNERS, NCORNERS);
    endcase
    write_reg(piw_pkg::REG_CORNER_COUNT, count_word);
    case ($urandom_range(0, 7))
      0: eps_word = '0;
      1: eps_word = 32'd1;
      2: eps_word = '1;
      3: eps_word = $urandom;
      default: eps_word = $urandom_range(1, 1 << $urandom_range(1, 24));
    endcase
    write_reg(piw_pkg::REG_EPSILON, eps_word);
    n = used_corners();
    load_polygon(n, load_all);
    repeat ($urandom_range(20, 50)) begin
      if ($urandom_range(0, 11) == 0)
        load_corner(idx_t'($urandom), coord_t'($urandom), coord_t'($urandom));
      else query_near_polygon(n);
    end
  endtask

  task automatic test_random_polygons();
    bit load_all;
    load_all = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      // the first polygon writes every slot so later counts never read an empty one
      run_polygon_phase(load_all);
      load_all = 1'b0;
    end
  endtask

  initial begin : result_ready_driver
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [piw_pkg::LOC_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (loc_expected.size() == 0) begin
        note_mismatch($sformatf("location %0d with no query waiting",
                                out_tdata[piw_pkg::LOC_W-1:0]));
      end else begin
        want = loc_expected.pop_front();
        if (out_tdata[piw_pkg::LOC_W-1:0] !== want)
          note_mismatch($sformatf("location: expected %0d, got %0d",
                                  want, out_tdata[piw_pkg::LOC_W-1:0]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = piw_pkg::OP_LOAD;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = piw_pkg::REG_CORNER_COUNT;
    cfg_data = '0;
    corner_count_q = piw_pkg::CORNER_COUNT_RST;
    epsilon_q = piw_pkg::EPSILON_RST;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_on = 1'b1;
    test_default_triangle();
    test_epsilon_extremes();
    test_count_clamping();
    test_random_polygons();
    wait_idle();
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
sv/piw_pkg.sv
sv/point_in_polygon_winding_unit.sv
test/point_in_polygon_winding_unit_tb.sv
